/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define XCPF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define XCPF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define XCPF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define XCPF_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/xcpf_pkg.sv */
// Types, constants and the CRC helper for the XMODEM-CRC packet framer.
package xcpf_pkg;

  localparam int PAYLOAD_BYTES = 128;
  localparam int IDX_W         = 7;
  localparam int MAX_RES       = 4;
  localparam int CNT_W         = 3;

  localparam logic [7:0]  START_BYTE = 8'h01;
  localparam logic [7:0]  BYTE_MASK  = 8'hff;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'h0000;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(PAYLOAD_BYTES - 1);

  // One accepted input transfer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] packet_number;
  } byte_item_t;

  // One output transfer of the framed stream.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
  } frame_item_t;

  // Folds one byte into a CRC-16-CCITT, MSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/xmodem_crc_packet_framer_unit.sv */
// Top level of the XMODEM-CRC packet framer.
//
// The byte channel (byte_valid, byte_stall, byte_item) takes one payload byte
// and the packet number per transfer. The frame channel (frame_valid,
// frame_stall, frame_item) delivers the framed stream one byte per transfer.
// The first payload byte of a packet gives four frame bytes: start byte,
// packet number, its complement and the data byte. A middle byte gives one,
// and the last byte of a packet gives three: data, CRC high and CRC low.
// The CRC is folded into the running value as each byte is accepted.
// The first frame byte of an item passes the pending registers, then the output
// register. With an idle receiver a middle payload byte is taken every cycle;
// after the first or last byte of a packet the next byte waits until all of its
// frame bytes have entered the output register; the frame port sends one byte per cycle.
// A stalled receiver holds the output register; the pending item waits behind
// it, and the byte channel stalls until that item has moved out completely.
// Reset clears the packet position, the CRC and both valid stages.
`include "assert_macros.svh"

module xmodem_crc_packet_framer_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  xcpf_pkg::byte_item_t   byte_item,
  output logic                   frame_valid,
  input  logic                   frame_stall,
  output xcpf_pkg::frame_item_t  frame_item
);
  import xcpf_pkg::*;

  // Packet state.
  logic [IDX_W-1:0] byte_index;
  logic [15:0]      crc_value;

  // Pending item: its frame bytes in transmit order, shifted out one by one.
  logic [7:0]       pend_bytes [MAX_RES];
  logic [7:0]       pend_bytes_next [MAX_RES];
  logic [CNT_W-1:0] pend_cnt;
  logic [CNT_W-1:0] pend_cnt_next;
  logic             pend_end;
  logic             pend_end_next;

  logic             out_load;
  logic             pend_free;
  logic             byte_acc;
  logic             first_byte;
  logic             last_byte;
  logic [15:0]      crc_next;

  // Handshake: the pending item frees as its last byte enters the output register.
  always_comb begin
    out_load   = (pend_cnt != '0) && (!frame_valid || !frame_stall);
    pend_free  = (pend_cnt == '0) || (out_load && (pend_cnt == CNT_W'(1)));
    byte_stall = !pend_free;
    byte_acc   = byte_valid && !byte_stall;
  end

  // Frame bytes for a newly accepted payload byte.
  always_comb begin
    first_byte = (byte_index == '0);
    last_byte  = (byte_index >= LAST_INDEX);
    crc_next   = crc_fold(crc_value, byte_item.data_byte);
    for (int i = 0; i < MAX_RES; i++) begin
      pend_bytes_next[i] = 8'h00;
    end
    pend_end_next = 1'b0;
    if (first_byte) begin
      pend_bytes_next[0] = START_BYTE;
      pend_bytes_next[1] = byte_item.packet_number;
      pend_bytes_next[2] = byte_item.packet_number ^ BYTE_MASK;
      pend_bytes_next[3] = byte_item.data_byte;
      pend_cnt_next      = CNT_W'(4);
    end else if (last_byte) begin
      pend_bytes_next[0] = byte_item.data_byte;
      pend_bytes_next[1] = crc_next[15:8];
      pend_bytes_next[2] = crc_next[7:0];
      pend_cnt_next      = CNT_W'(3);
      pend_end_next      = 1'b1;
    end else begin
      pend_bytes_next[0] = byte_item.data_byte;
      pend_cnt_next      = CNT_W'(1);
    end
  end

  // Control state: packet position, CRC, pending count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      crc_value   <= CRC_INIT;
      pend_cnt    <= '0;
      frame_valid <= 1'b0;
    end else begin
      if (byte_acc) begin
        pend_cnt <= pend_cnt_next;
        if (last_byte) begin
          byte_index <= '0;
          crc_value  <= CRC_INIT;
        end else begin
          byte_index <= byte_index + IDX_W'(1);
          crc_value  <= crc_next;
        end
      end else if (out_load) begin
        pend_cnt <= pend_cnt - CNT_W'(1);
      end
      if (out_load) begin
        frame_valid <= 1'b1;
      end else if (!frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
  end

  // Payload registers: pending bytes and the output register.
  always_ff @(posedge clk) begin
    if (byte_acc) begin
      pend_bytes <= pend_bytes_next;
      pend_end   <= pend_end_next;
    end else if (out_load) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        pend_bytes[i] <= pend_bytes[i+1];
      end
      pend_bytes[MAX_RES-1] <= 8'h00;
    end
    if (out_load) begin
      frame_item.out_byte   <= pend_bytes[0];
      frame_item.run_last   <= (pend_cnt == CNT_W'(1));
      frame_item.packet_end <= (pend_cnt == CNT_W'(1)) && pend_end;
    end
  end

  // Checks on the framing logic.
  `XCPF_ASSERT_IMP(a_end_is_last, clk, rst, frame_valid && frame_item.packet_end, frame_item.run_last)
  `XCPF_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, pend_cnt <= CNT_W'(MAX_RES))
  `XCPF_ASSERT_NXT(a_header_len, clk, rst, byte_acc && (byte_index == '0), pend_cnt == CNT_W'(MAX_RES))
  `XCPF_ASSERT_NXT(a_crc_cleared, clk, rst, byte_acc && (byte_index >= LAST_INDEX), (byte_index == '0) && (crc_value == CRC_INIT))

endmodule

/* sim/xmodem_crc_packet_framer_unit_test.sv */
// Self-checking testbench for the XMODEM-CRC packet framer top level.
module xmodem_crc_packet_framer_unit_test;
  import xcpf_pkg::*;

  localparam int HOLD_CYCLES   = 60;
  localparam int IDLE_LIMIT    = 1000;
  localparam int MAX_REPORTED  = 10;
  localparam int DRAIN_CYCLES  = 8;
  localparam logic [15:0] CCITT_POLY = 16'h1021;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  byte_item_t  byte_item = '0;
  logic        frame_valid;
  logic        frame_stall = 1'b0;
  frame_item_t frame_item;

  // Framed bytes still owed by the block, oldest first.
  frame_item_t frame_bytes_expected[$];

  // Shadow copy of the packet position and the running CRC.
  int          pkt_pos = 0;
  logic [15:0] running_crc = 16'h0000;

  int mismatch_count = 0;
  int idle_cycles = 0;
  int hold_request_cycles = 0;
  int rx_hold_left = 0;
  int rx_run_left = 0;
  bit sender_steady = 1'b1;
  bit receiver_steady = 1'b1;

  xmodem_crc_packet_framer_unit uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_item  (frame_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Length of an idle stretch: mostly none or short, now and then long.
  function automatic int pick_idle_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Payload byte with extra weight on all-zero and all-one values.
  function automatic logic [7:0] pick_data_byte();
    if ($urandom_range(0, 9) == 0) begin
      return ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // CRC-16-CCITT update, one message bit at a time.
  function automatic logic [15:0] crc_after_byte(input logic [15:0] crc,
                                                 input logic [7:0] data);
    logic [15:0] c;
    logic        feedback;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = c[15] ^ data[i];
      c = {c[14:0], 1'b0} ^ (feedback ? CCITT_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void owe_frame_byte(input logic [7:0] value, input logic closes);
    frame_item_t f;
    f.out_byte   = value;
    f.run_last   = 1'b0;
    f.packet_end = closes;
    frame_bytes_expected.push_back(f);
  endfunction

  // Works out the framed bytes caused by one accepted payload byte.
  function automatic void predict_frame_bytes(input logic [7:0] data,
                                              input logic [7:0] number);
    if (pkt_pos == 0) begin
      owe_frame_byte(START_BYTE, 1'b0);
      owe_frame_byte(number, 1'b0);
      owe_frame_byte(~number, 1'b0);
    end
    owe_frame_byte(data, 1'b0);
    running_crc = crc_after_byte(running_crc, data);
    if (pkt_pos >= PAYLOAD_BYTES - 1) begin
      owe_frame_byte(running_crc[15:8], 1'b0);
      owe_frame_byte(running_crc[7:0], 1'b1);
      pkt_pos = 0;
      running_crc = 16'h0000;
    end else begin
      pkt_pos++;
    end
    frame_bytes_expected[frame_bytes_expected.size() - 1].run_last = 1'b1;
  endfunction

  // Compares one framed byte with the oldest one owed.
  function automatic void check_frame_byte(input frame_item_t got);
    frame_item_t want;
    if (frame_bytes_expected.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
        $display("unexpected frame byte %02h run_last %0b packet_end %0b",
                 got.out_byte, got.run_last, got.packet_end);
      end
      return;
    end
    want = frame_bytes_expected.pop_front();
    if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
        got.packet_end !== want.packet_end) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
        $display("frame byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                 want.out_byte, want.run_last, want.packet_end,
                 got.out_byte, got.run_last, got.packet_end);
      end
    end
  endfunction

  // Offers one payload byte, after an optional gap, until it is accepted.
  task automatic send_byte(input logic [7:0] data, input logic [7:0] number);
    int gap;
    gap = sender_steady ? 0 : pick_idle_run();
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item.data_byte <= data;
    byte_item.packet_number <= number;
    do @(posedge clk); while (byte_stall);
    predict_frame_bytes(data, number);
  endtask

  // Receiver: checks each frame transfer, then picks the next stall value.
  always @(posedge clk) begin
    if (!rst && frame_valid && !frame_stall) begin
      check_frame_byte(frame_item);
    end
    if (hold_request_cycles > 0) begin
      rx_hold_left = hold_request_cycles;
      hold_request_cycles = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      frame_stall <= 1'b1;
    end else if (receiver_steady) begin
      frame_stall <= 1'b0;
    end else if (rx_run_left > 0) begin
      rx_run_left--;
    end else begin
      rx_run_left = pick_idle_run();
      if (rx_run_left == 0) begin
        frame_stall <= 1'b0;
        rx_run_left = $urandom_range(0, 5);
      end else begin
        frame_stall <= 1'b1;
        rx_run_left--;
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (frame_valid && !frame_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("xmodem_crc_packet_framer_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Packet header and payload built from all-zero, all-one and edge bytes.
  task automatic test_extreme_bytes();
    logic [7:0] pattern [12];
    pattern = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe,
                8'haa, 8'h55, 8'h00, 8'h00, 8'hff, 8'hff};
    sender_steady = 1'b1;
    receiver_steady = 1'b1;
    send_byte(pattern[0], 8'h00);
    for (int i = 1; i < 12; i++) begin
      send_byte(pattern[i], 8'hff);
    end
  endtask

  // Packet numbers on later bytes of a packet must not reach the output.
  task automatic test_later_packet_numbers();
    logic [7:0] numbers [8];
    numbers = '{8'h00, 8'hff, 8'h01, 8'h80, 8'ha5, 8'h5a, 8'h7f, 8'hfe};
    for (int i = 0; i < 8; i++) begin
      send_byte(pick_data_byte(), numbers[i]);
    end
  endtask

  // Random payload and packet numbers with random gaps on both sides.
  task automatic test_random_stream(input int count);
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_byte(pick_data_byte(), 8'($urandom_range(0, 255)));
    end
  endtask

  // Long receiver hold while bytes keep coming, across a packet boundary.
  task automatic test_receiver_hold(input int count);
    sender_steady = 1'b1;
    receiver_steady = 1'b0;
    hold_request_cycles = HOLD_CYCLES;
    for (int i = 0; i < count; i++) begin
      send_byte(pick_data_byte(), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_extreme_bytes();
    test_later_packet_numbers();
    test_random_stream(220);
    test_receiver_hold(30);
    test_random_stream(114);
    byte_valid <= 1'b0;
    while (frame_bytes_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frame_bytes_expected.size() == 0) begin
      $display("xmodem_crc_packet_framer_unit test passed");
    end else begin
      $display("xmodem_crc_packet_framer_unit test failed");
    end
    $finish;
  end

endmodule
